/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle that implies another condition in the next cycle.
`define PDD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/pdd_pkg.sv */
package pdd_pkg;

  localparam int STAMP_W    = 32;
  localparam int DUTY_W     = 7;
  localparam int CODE_W     = 10;
  localparam int DIVIDEND_W = 39;
  localparam int DIVISOR_W  = 33;
  localparam int QUO_W      = 10;
  localparam int DEN_W      = DIVISOR_W + QUO_W - 1;
  localparam int STEP_W     = 4;

  localparam logic [STEP_W-1:0] DIV_STEPS = 4'd10;
  localparam logic [STEP_W-1:0] DIV_LAST  = 4'd9;

  localparam logic [DUTY_W-1:0] DUTY_FULL        = 7'd100;
  localparam logic [CODE_W-1:0] FULL_SCALE_RESET = 10'd620;

  // Rounded-up reciprocal of 100 at 2^24; exact for every product below 2^17.
  localparam int                  SCALE_SHIFT = 24;
  localparam int                  SCALE_MW    = 18;
  localparam logic [SCALE_MW-1:0] SCALE_MUL   = 18'd167773;

  typedef struct packed {
    logic capture;
    logic rise_upd;
    logic fall_prep;
    logic div_load;
    logic div_step;
    logic ring_store;
    logic avg_calc;
    logic scale_mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic expect_rising;
  } stat_t;

endpackage

/* rtl/pdd_datapath.sv */
module pdd_datapath #(
  parameter int SAMPLES = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pdd_pkg::cmd_t                      cmd,
  output pdd_pkg::stat_t                     stat,
  input  logic                               in_op,
  input  logic [pdd_pkg::STAMP_W-1:0]        in_stamp,
  input  logic                               cfg_wr_en,
  input  logic [pdd_pkg::CODE_W-1:0]         cfg_wr_data,
  output logic [pdd_pkg::CODE_W-1:0]         out_code
);

  localparam int IDX_W     = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int SUM_W     = $clog2(SAMPLES * 100 + 1);
  localparam int PROD_W    = pdd_pkg::DUTY_W + pdd_pkg::CODE_W;
  localparam int AVG_SHIFT = 20;
  localparam int AVG_MW    = AVG_SHIFT + 1;
  localparam int AVG_PW    = SUM_W + AVG_MW;
  localparam int OUT_PW    = PROD_W + pdd_pkg::SCALE_MW;
  // Rounded-up reciprocal of SAMPLES; exact for every ring sum below 2^13.
  localparam logic [AVG_MW-1:0] AVG_MUL =
    AVG_MW'((2 ** AVG_SHIFT + SAMPLES - 1) / SAMPLES);

  logic                              op_r;
  logic [pdd_pkg::STAMP_W-1:0]       stamp_r;
  logic [pdd_pkg::STAMP_W-1:0]       last_stamp_r;
  logic [pdd_pkg::STAMP_W-1:0]       low_time_r;
  logic [pdd_pkg::STAMP_W-1:0]       high_r;
  logic                              expect_rising_r;
  logic [pdd_pkg::CODE_W-1:0]        fsc_r;

  logic [pdd_pkg::DUTY_W-1:0]        ring_mem [SAMPLES];
  logic [SAMPLES-1:0]                ring_vld_r;
  logic [pdd_pkg::DUTY_W-1:0]        old_r;
  logic [IDX_W-1:0]                  ring_idx_r;
  logic [SUM_W-1:0]                  sum_r;

  logic [pdd_pkg::DIVIDEND_W-1:0]    rem_r;
  logic [pdd_pkg::DEN_W-1:0]         den_r;
  logic [pdd_pkg::QUO_W-1:0]         quo_r;
  logic                              zero_period_r;
  logic [pdd_pkg::DUTY_W-1:0]        avg_r;
  logic [PROD_W-1:0]                 prod_r;
  logic [pdd_pkg::CODE_W-1:0]        out_data_r;

  logic [pdd_pkg::DIVIDEND_W-1:0]    dividend;
  logic [pdd_pkg::DIVISOR_W-1:0]     divisor;
  logic [pdd_pkg::DIVIDEND_W-1:0]    high_ext;
  logic [AVG_PW-1:0]                 avg_prod;
  logic [OUT_PW-1:0]                 out_prod;
  logic                              div_ge;
  logic [pdd_pkg::DEN_W-1:0]         rem_diff;
  logic [pdd_pkg::DUTY_W-1:0]        duty;

  assign high_ext = pdd_pkg::DIVIDEND_W'(high_r);

  // high * 100 written as shifts: 64 + 32 + 4.
  assign dividend = (high_ext << 6) + (high_ext << 5) + (high_ext << 2);
  assign divisor  = {1'b0, high_r} + {1'b0, low_time_r};

  assign avg_prod = AVG_PW'(sum_r) * AVG_PW'(AVG_MUL);
  assign out_prod = OUT_PW'(prod_r) * OUT_PW'(pdd_pkg::SCALE_MUL);

  // Every quotient produced here is below 1024, so ten restoring steps suffice.
  assign rem_diff = pdd_pkg::DEN_W'(rem_r) - den_r;
  assign div_ge   = pdd_pkg::DEN_W'(rem_r) >= den_r;

  always_comb begin
    if (zero_period_r) begin
      duty = '0;
    end else if (quo_r > pdd_pkg::QUO_W'(pdd_pkg::DUTY_FULL)) begin
      duty = pdd_pkg::DUTY_FULL;
    end else begin
      duty = quo_r[pdd_pkg::DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_op;
      stamp_r <= in_stamp;
    end
    if (cmd.fall_prep) begin
      high_r <= stamp_r - last_stamp_r;
      old_r  <= ring_vld_r[ring_idx_r] ? ring_mem[ring_idx_r] : '0;
    end
    if (cmd.div_load) begin
      rem_r         <= dividend;
      den_r         <= {divisor, {(pdd_pkg::QUO_W-1){1'b0}}};
      quo_r         <= '0;
      zero_period_r <= (divisor == '0);
    end else if (cmd.div_step) begin
      if (div_ge) begin
        rem_r <= rem_diff[pdd_pkg::DIVIDEND_W-1:0];
      end
      quo_r <= {quo_r[pdd_pkg::QUO_W-2:0], div_ge};
      den_r <= den_r >> 1;
    end
    if (cmd.ring_store) begin
      ring_mem[ring_idx_r] <= duty;
    end
    if (cmd.avg_calc) begin
      avg_r <= avg_prod[AVG_SHIFT +: pdd_pkg::DUTY_W];
    end
    if (cmd.scale_mul) begin
      prod_r <= PROD_W'(avg_r) * PROD_W'(fsc_r);
    end
    if (cmd.out_load) begin
      out_data_r <= out_prod[pdd_pkg::SCALE_SHIFT +: pdd_pkg::CODE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_stamp_r    <= '0;
      low_time_r      <= '0;
      expect_rising_r <= 1'b1;
      ring_vld_r      <= '0;
      ring_idx_r      <= '0;
      sum_r           <= '0;
      fsc_r           <= pdd_pkg::FULL_SCALE_RESET;
    end else begin
      if (cfg_wr_en) begin
        fsc_r <= cfg_wr_data;
      end
      if (cmd.rise_upd) begin
        low_time_r      <= stamp_r - last_stamp_r;
        last_stamp_r    <= stamp_r;
        expect_rising_r <= 1'b0;
      end
      if (cmd.fall_prep) begin
        last_stamp_r <= stamp_r;
      end
      if (cmd.ring_store) begin
        ring_vld_r[ring_idx_r] <= 1'b1;
        // The running sum swaps the overwritten entry for the new one.
        sum_r           <= sum_r + SUM_W'(duty) - SUM_W'(old_r);
        expect_rising_r <= 1'b1;
        if (ring_idx_r == IDX_W'(SAMPLES - 1)) begin
          ring_idx_r <= '0;
        end else begin
          ring_idx_r <= ring_idx_r + 1'b1;
        end
      end
    end
  end

  assign stat.op            = op_r;
  assign stat.expect_rising = expect_rising_r;
  assign out_code           = out_data_r;

`include "assert_macros.svh"

  `PDD_ASSERT(a_idx_range, ring_idx_r <= IDX_W'(SAMPLES - 1), "ring index out of range")
  `PDD_ASSERT(a_sum_bound, sum_r <= SUM_W'(SAMPLES * 100), "ring sum above its bound")

endmodule

/* rtl/pdd_ctrl.sv */
module pdd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  pdd_pkg::stat_t stat,
  output pdd_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_DISPATCH   = 3'd1;
  localparam logic [2:0] S_FALL_LOAD  = 3'd2;
  localparam logic [2:0] S_DIV        = 3'd3;
  localparam logic [2:0] S_FALL_STORE = 3'd4;
  localparam logic [2:0] S_SCALE      = 3'd5;
  localparam logic [2:0] S_OUT        = 3'd6;

  logic [2:0]                  state_r, state_nxt;
  logic [pdd_pkg::STEP_W-1:0]  cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (stat.op) begin
          cmd.avg_calc = 1'b1;
          state_nxt    = S_SCALE;
        end else if (stat.expect_rising) begin
          cmd.rise_upd = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.fall_prep = 1'b1;
          state_nxt     = S_FALL_LOAD;
        end
      end
      S_FALL_LOAD: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == pdd_pkg::DIV_LAST) begin
          state_nxt = S_FALL_STORE;
        end
      end
      S_FALL_STORE: begin
        cmd.ring_store = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_SCALE: begin
        cmd.scale_mul = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        // Wait here only while the previous result is still held.
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

`include "assert_macros.svh"

  `PDD_ASSERT(a_div_count, (state_r != S_DIV) || (cnt_r < pdd_pkg::DIV_STEPS),
              "divider step count overran")
  `PDD_ASSERT_NEXT(a_out_hold, out_valid_r && !out_tready, out_valid_r,
                   "stalled result dropped")
  `PDD_ASSERT_NEXT(a_out_wait, (state_r == S_OUT) && out_valid_r && !out_tready,
                   state_r == S_OUT, "new result overwrote a stalled one")

endmodule

/* rtl/pwm_duty_demodulator_unit.sv */
// PWM duty-cycle demodulator with a moving average over SAMPLES duty values.
// Input channel: in_tdata carries a captured timer value, in_tuser the kind
// of item (0 = edge timestamp, 1 = update tick). Edges alternate rising and
// falling, starting with rising. Edge items give no result; an update tick
// gives one DAC code on the output channel.
// cfg_wr_en / cfg_wr_data set the DAC code for full duty (reset value 620);
// write it only while no item is in flight.
// Items are taken one at a time: in_tready is high only while idle. A
// falling edge runs the ten-step restoring divider that forms the duty
// value; a tick forms the average, the scaling product and the output
// code in turn, all by multiplication. out_tvalid rises together with
// the registered output code.
// While a result waits for out_tready, further items are still accepted; a
// second tick then waits at its end until the first result has been taken.
// A synchronous reset clears the ring, the running sum and the edge tracking,
// and reloads the full-scale register with 620; no clearing pass is needed.
module pwm_duty_demodulator_unit #(
  parameter int SAMPLES = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] timestamp
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] dac_code, [15:10] zero
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data
);

  pdd_pkg::cmd_t                cmd;
  pdd_pkg::stat_t               stat;
  logic [pdd_pkg::CODE_W-1:0]   out_code;

  pdd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pdd_datapath #(
    .SAMPLES (SAMPLES)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_op       (in_tuser),
    .in_stamp    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_code    (out_code)
  );

  assign out_tdata = {6'b0, out_code};

endmodule

/* sim/tb_pwm_duty_demodulator_unit.sv */
localparam int RING_LEN = 10;
localparam logic OP_EDGE = 1'b0;
localparam logic OP_TICK = 1'b1;

// Tracks the edge pairing, the duty ring and the full-scale code, and keeps
// the DAC codes that update ticks have yet to produce.
class duty_scoreboard;
  logic [pdd_pkg::CODE_W-1:0]  full_scale;
  logic [pdd_pkg::STAMP_W-1:0] last_stamp;
  logic [pdd_pkg::STAMP_W-1:0] low_time;
  logic                        expect_rising;
  logic [pdd_pkg::DUTY_W-1:0]  duty_ring[RING_LEN];
  int unsigned                 ring_pos;
  logic [pdd_pkg::CODE_W-1:0]  expected_codes[$];
  int unsigned                 failures;

  function new();
    full_scale = pdd_pkg::FULL_SCALE_RESET;
    last_stamp = '0;
    low_time = '0;
    expect_rising = 1'b1;
    foreach (duty_ring[i]) duty_ring[i] = '0;
    ring_pos = 0;
    failures = 0;
  endfunction

  function void note_item(logic op, logic [pdd_pkg::STAMP_W-1:0] stamp);
    logic [pdd_pkg::STAMP_W-1:0] high_time;
    logic [63:0]                 period;
    logic [63:0]                 quotient;
    logic [63:0]                 total;
    if (op == OP_TICK) begin
      total = '0;
      foreach (duty_ring[i]) total += {57'd0, duty_ring[i]};
      total = total / RING_LEN;
      total = total * {54'd0, full_scale} / {57'd0, pdd_pkg::DUTY_FULL};
      expected_codes.push_back(total[pdd_pkg::CODE_W-1:0]);
      return;
    end
    if (expect_rising) begin
      low_time = stamp - last_stamp;
      expect_rising = 1'b0;
    end else begin
      high_time = stamp - last_stamp;
      // The period is summed wide so that it never wraps.
      period = {32'd0, high_time} + {32'd0, low_time};
      if (period == 0) begin
        quotient = '0;
      end else begin
        quotient = {32'd0, high_time} * {57'd0, pdd_pkg::DUTY_FULL} / period;
        if (quotient > pdd_pkg::DUTY_FULL) quotient = {57'd0, pdd_pkg::DUTY_FULL};
      end
      duty_ring[ring_pos] = quotient[pdd_pkg::DUTY_W-1:0];
      ring_pos = (ring_pos + 1) % RING_LEN;
      expect_rising = 1'b1;
    end
    last_stamp = stamp;
  endfunction

  function void check_code(logic [pdd_pkg::CODE_W-1:0] code);
    logic [pdd_pkg::CODE_W-1:0] want;
    if (expected_codes.size() == 0) begin
      $error("dac_code: no result expected, actual %0d", code);
      failures++;
      return;
    end
    want = expected_codes.pop_front();
    if (code !== want) begin
      $error("dac_code: expected %0d, actual %0d", want, code);
      failures++;
    end
  endfunction
endclass

module tb_pwm_duty_demodulator_unit;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE = 40;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] timestamp
  logic        in_tuser;   // [0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [9:0] dac_code, [15:10] zero
  logic        cfg_wr_en;
  logic [9:0]  cfg_wr_data;

  logic        steady;
  logic [31:0] now_stamp;
  int unsigned cycle_count = 0;
  int unsigned phase;
  duty_scoreboard sb;

  pwm_duty_demodulator_unit #(
    .SAMPLES(RING_LEN)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = steady || ($urandom_range(99) >= 24);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_code(out_tdata[pdd_pkg::CODE_W-1:0]);
    end
  end

  task automatic send_item(input logic op, input logic [31:0] stamp);
    while (!steady && $urandom_range(99) < 24) @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = stamp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(op, stamp);
    @(negedge clk);
    in_tvalid = 1'b0;
    in_tdata = $urandom;
    in_tuser = 1'($urandom_range(1));
  endtask

  // Waits for every outstanding code, then lets a falling edge finish.
  task automatic drain();
    while (sb.expected_codes.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_scale(input logic [pdd_pkg::CODE_W-1:0] value);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.full_scale = value;
  endtask

  function automatic logic [31:0] pick_span();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return $urandom_range(50, 1);
      2: return $urandom_range(65535);
      3: return $urandom;
      default: return $urandom_range(2000, 1);
    endcase
  endfunction

  // Mostly whole pulses with random widths; some stray edges and ticks.
  task automatic random_items(input int unsigned count);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_item(OP_TICK, $urandom);
        sent++;
      end else if (pick < 22) begin
        now_stamp = $urandom;
        send_item(OP_EDGE, now_stamp);
        sent++;
      end else begin
        if (!sb.expect_rising) begin
          now_stamp += $urandom_range(200);
          send_item(OP_EDGE, now_stamp);
          sent++;
        end
        now_stamp += pick_span();
        send_item(OP_EDGE, now_stamp);
        now_stamp += pick_span();
        send_item(OP_EDGE, now_stamp);
        sent += 2;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_EDGE;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    steady = 1'b0;
    now_stamp = '0;
    sb = new();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // The ring is all zeros straight after reset.
    send_item(OP_TICK, 32'hFFFF_FFFF);
    // A rising and a falling edge at the same stamp give a zero period.
    send_item(OP_EDGE, 32'h0000_0000);
    send_item(OP_EDGE, 32'h0000_0000);
    // Only the high-time difference wraps past the top of the timer.
    send_item(OP_EDGE, 32'hFFFF_FFF0);
    send_item(OP_EDGE, 32'h0000_0010);
    // No low time and the longest high time give full duty.
    send_item(OP_EDGE, 32'h0000_0010);
    send_item(OP_EDGE, 32'h0000_000F);
    now_stamp = 32'h0000_000F;
    for (int i = 0; i < RING_LEN - 1; i++) begin
      send_item(OP_EDGE, now_stamp);
      now_stamp += 32'd1000;
      send_item(OP_EDGE, now_stamp);
    end
    send_item(OP_TICK, 32'h0000_0000);

    random_items(100);
    for (phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: write_scale(10'd0);
        1: write_scale(10'd1023);
        2: write_scale(10'($urandom_range(1022, 1)));
        default: write_scale(10'd100);
      endcase
      steady = (phase == 2);
      random_items(100);
    end
    steady = 1'b0;
    drain();

    if (sb.failures == 0 && sb.expected_codes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
